// ----- rtl/key_debounce_gesture_detector_unit_defines.svh -----
// ---------------------------------------------------------------------------
// key debounce gesture detector: assertion macros
// shared concurrent assertion forms used by the port checker
// ---------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_GESTURE_DETECTOR_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_GESTURE_DETECTOR_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define KDG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define KDG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/kdg_pkg.sv -----
// ---------------------------------------------------------------------------
// kdg_pkg
// shared types and constants of the key debounce gesture detector
// ---------------------------------------------------------------------------
package kdg_pkg;

  localparam int NUM_KEYS_DEF = 6;
  localparam int KEY_FIELD_W  = 6;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 8;
  localparam int MS_W         = 16;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int CODE_W       = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PERIOD  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK   = 2'd3;

  // register reset values
  localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST = 8'd20;
  localparam logic [MS_W-1:0]  REPEAT_DELAY_RST   = 16'd500;
  localparam logic [MS_W-1:0]  REPEAT_PERIOD_RST  = 16'd50;
  localparam logic [MS_W-1:0]  DOUBLE_CLICK_RST   = 16'd200;

  typedef enum logic [CODE_W-1:0] {
    EV_NONE   = 3'd0,
    EV_PRESS  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_HOLD   = 3'd3,
    EV_AUTO   = 3'd4
  } event_code_t;

  typedef struct packed {
    logic        fire;
    event_code_t code;
  } kdg_event_t;

endpackage

// ----- rtl/kdg_debounce.sv -----
// ---------------------------------------------------------------------------
// kdg_debounce
// per-key debounce counters and the debounced key vector
// ---------------------------------------------------------------------------
module kdg_debounce #(
  parameter int NUM_KEYS = kdg_pkg::NUM_KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [NUM_KEYS-1:0]        raw,
  input  logic [kdg_pkg::CNT_W-1:0]  ticks,
  output logic [NUM_KEYS-1:0]        stable,
  output logic [NUM_KEYS-1:0]        stable_next,
  output logic                       new_press
);
  import kdg_pkg::*;

  logic [CNT_W-1:0]    cnt [NUM_KEYS];
  logic [CNT_W-1:0]    cnt_next [NUM_KEYS];
  logic [NUM_KEYS-1:0] press_vec;

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_key
    always_comb begin
      cnt_next[i]    = cnt[i];
      stable_next[i] = stable[i];
      press_vec[i]   = 1'b0;
      if (cnt[i] != '0) begin
        cnt_next[i] = cnt[i] - 1'b1;
      end else if (raw[i] && !stable[i]) begin
        stable_next[i] = 1'b1;
        cnt_next[i]    = ticks;
        press_vec[i]   = 1'b1;
      end else if (!raw[i] && stable[i]) begin
        stable_next[i] = 1'b0;
        cnt_next[i]    = ticks;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        cnt[i]    <= '0;
        stable[i] <= 1'b0;
      end else if (en) begin
        cnt[i]    <= cnt_next[i];
        stable[i] <= stable_next[i];
      end
    end
  end

  assign new_press = |press_vec;

endmodule

// ----- rtl/kdg_classify.sv -----
// ---------------------------------------------------------------------------
// kdg_classify
// press, double click, hold and auto-repeat classification of the keyset
// ---------------------------------------------------------------------------
module kdg_classify #(
  parameter int NUM_KEYS = kdg_pkg::NUM_KEYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [NUM_KEYS-1:0]        stable,
  input  logic [NUM_KEYS-1:0]        stable_next,
  input  logic                       new_press,
  input  logic [kdg_pkg::TIME_W-1:0] now,
  input  logic [kdg_pkg::MS_W-1:0]   repeat_delay,
  input  logic [kdg_pkg::MS_W-1:0]   repeat_period,
  input  logic [kdg_pkg::MS_W-1:0]   double_click,
  output kdg_pkg::kdg_event_t        ev
);
  import kdg_pkg::*;

  logic [NUM_KEYS-1:0] last_pressed;
  logic [NUM_KEYS-1:0] last_pressed_next;
  logic [TIME_W-1:0]   double_dl;
  logic [TIME_W-1:0]   double_dl_next;
  logic [TIME_W-1:0]   repeat_dl;
  logic [TIME_W-1:0]   repeat_dl_next;
  logic                held;
  logic                held_next;
  event_code_t         code;

  always_comb begin
    last_pressed_next = last_pressed;
    double_dl_next    = double_dl;
    repeat_dl_next    = repeat_dl;
    held_next         = held;
    code              = EV_NONE;
    if (stable_next == '0) begin
      held_next      = 1'b0;
      repeat_dl_next = '0;
    end else if (stable_next != stable) begin
      held_next = 1'b0;
      if (new_press) begin
        if (stable_next == last_pressed && now < double_dl) begin
          code = EV_DOUBLE;
        end else begin
          code = EV_PRESS;
        end
        last_pressed_next = stable_next;
        double_dl_next    = now + {{(TIME_W-MS_W){1'b0}}, double_click};
      end
      repeat_dl_next = now + {{(TIME_W-MS_W){1'b0}}, repeat_delay};
    end else if (repeat_dl < now) begin
      code           = held ? EV_AUTO : EV_HOLD;
      held_next      = 1'b1;
      repeat_dl_next = now + {{(TIME_W-MS_W){1'b0}}, repeat_period};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_pressed <= '0;
      double_dl    <= '0;
      repeat_dl    <= '0;
      held         <= 1'b0;
    end else if (en) begin
      last_pressed <= last_pressed_next;
      double_dl    <= double_dl_next;
      repeat_dl    <= repeat_dl_next;
      held         <= held_next;
    end
  end

  assign ev.fire = (code != EV_NONE);
  assign ev.code = code;

endmodule

// ----- rtl/key_debounce_gesture_detector_unit.sv -----
// ---------------------------------------------------------------------------
// key_debounce_gesture_detector_unit
// debounces a set of keys per tick and reports press, double click, hold and
// auto-repeat events together with the debounced keyset
// ---------------------------------------------------------------------------
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------
//  in      | in_valid/in_stall | raw_pressed, now_ms
//  out     | out_valid/out_stall | event_code, keyset
//  cfg     | cfg_we            | cfg_index, cfg_data
//
//  one tick is taken per cycle while in_stall is low; its event, if any,
//  reaches out through the input register, then the result register
//  all gesture work for a tick sits between the input and result registers
//  rst is synchronous: counters, keys, deadlines and config go to defaults
//  a held result stalls the pipe only when the input register also holds a
//  tick; otherwise in keeps flowing into the empty input register
//
module key_debounce_gesture_detector_unit #(
  parameter int NUM_KEYS = kdg_pkg::NUM_KEYS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // tick input
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [kdg_pkg::KEY_FIELD_W-1:0] raw_pressed,
  input  logic [kdg_pkg::TIME_W-1:0]      now_ms,
  // event output
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [kdg_pkg::CODE_W-1:0]      event_code,
  output logic [kdg_pkg::KEY_FIELD_W-1:0] keyset,
  // config write port
  input  logic                            cfg_we,
  input  logic [kdg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kdg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import kdg_pkg::*;

  // config registers
  logic [CNT_W-1:0] debounce_ticks;
  logic [MS_W-1:0]  repeat_delay_ms;
  logic [MS_W-1:0]  repeat_period_ms;
  logic [MS_W-1:0]  double_click_ms;

  // input register
  logic                   in_reg_valid;
  logic [KEY_FIELD_W-1:0] in_raw;
  logic [TIME_W-1:0]      in_now;

  // pipe control
  logic in_take;
  logic advance;

  logic [NUM_KEYS-1:0]    raw_vec;
  logic [NUM_KEYS-1:0]    stable;
  logic [NUM_KEYS-1:0]    stable_next;
  logic [KEY_FIELD_W-1:0] keyset_next;
  logic                   new_press;
  kdg_event_t             ev;

  // the tick in the input register moves on whenever the result slot frees
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= DEBOUNCE_TICKS_RST;
      repeat_delay_ms  <= REPEAT_DELAY_RST;
      repeat_period_ms <= REPEAT_PERIOD_RST;
      double_click_ms  <= DOUBLE_CLICK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks   <= cfg_data[CNT_W-1:0];
        REG_REPEAT_DELAY:   repeat_delay_ms  <= cfg_data[MS_W-1:0];
        REG_REPEAT_PERIOD:  repeat_period_ms <= cfg_data[MS_W-1:0];
        REG_DOUBLE_CLICK:   double_click_ms  <= cfg_data[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_raw <= raw_pressed;
      in_now <= now_ms;
    end
  end

  // map raw contact bits onto the key vector; keys past the field read open
  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_raw
    if (i < KEY_FIELD_W) begin : g_in
      assign raw_vec[i] = in_raw[i];
    end else begin : g_open
      assign raw_vec[i] = 1'b0;
    end
  end

  kdg_debounce #(
    .NUM_KEYS (NUM_KEYS)
  ) u_debounce (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .raw         (raw_vec),
    .ticks       (debounce_ticks),
    .stable      (stable),
    .stable_next (stable_next),
    .new_press   (new_press)
  );

  kdg_classify #(
    .NUM_KEYS (NUM_KEYS)
  ) u_classify (
    .clk           (clk),
    .rst           (rst),
    .en            (advance),
    .stable        (stable),
    .stable_next   (stable_next),
    .new_press     (new_press),
    .now           (in_now),
    .repeat_delay  (repeat_delay_ms),
    .repeat_period (repeat_period_ms),
    .double_click  (double_click_ms),
    .ev            (ev)
  );

  // reported keyset is the low field-width keys, zero filled above NUM_KEYS
  for (genvar j = 0; j < KEY_FIELD_W; j++) begin : g_keyset
    if (j < NUM_KEYS) begin : g_key
      assign keyset_next[j] = stable_next[j];
    end else begin : g_pad
      assign keyset_next[j] = 1'b0;
    end
  end

  // result register: loads on advance, drains when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= ev.fire;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && ev.fire) begin
      event_code <= ev.code;
      keyset     <= keyset_next;
    end
  end

endmodule

// ----- rtl/kdg_checker.sv -----
// ---------------------------------------------------------------------------
// kdg_checker
// port-level checks of the key debounce gesture detector
// ---------------------------------------------------------------------------
`include "key_debounce_gesture_detector_unit_defines.svh"

module kdg_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic [kdg_pkg::KEY_FIELD_W-1:0] raw_pressed,
  input logic [kdg_pkg::TIME_W-1:0]      now_ms,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [kdg_pkg::CODE_W-1:0]      event_code,
  input logic [kdg_pkg::KEY_FIELD_W-1:0] keyset
);
  import kdg_pkg::*;

  // only real event codes leave the block
  `KDG_ASSERT_NOW(a_code_known, out_valid, (event_code >= EV_PRESS && event_code <= EV_AUTO), "event code out of range")

  // every event comes with at least one key down
  `KDG_ASSERT_NOW(a_keys_down, out_valid, keyset != '0, "event with empty keyset")

  // input backs up only behind a stalled result
  `KDG_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without output stall")

  // a stalled result holds
  `KDG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(event_code) && $stable(keyset), "stalled result changed")

  // a stalled tick holds
  `KDG_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(raw_pressed) && $stable(now_ms), "stalled tick changed")

endmodule

bind key_debounce_gesture_detector_unit kdg_checker u_kdg_checker (.*);

// ----- verif/tb_top.sv -----
// ---------------------------------------------------------------------------
// key debounce gesture detector testbench
// drives raw key ticks through the valid/stall input channel, tracks the
// debounce counters and gesture state in a local model, and compares every
// event on the output channel with the predicted code and keyset
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import kdg_pkg::*;

  localparam int KEYS        = NUM_KEYS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // input register plus result register, with margin for a tick that yields nothing
  localparam int PIPE_SETTLE = 4;
  localparam int HOLD_OFF    = 200;

  // one predicted event: code plus the debounced keyset
  typedef struct packed {
    event_code_t             code;
    logic [KEY_FIELD_W-1:0]  keys;
  } gesture_t;

  // dut ports; the driven inputs are known from time zero
  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   in_valid    = 1'b0;
  logic                   in_stall;
  logic [KEY_FIELD_W-1:0] raw_pressed = '0;
  logic [TIME_W-1:0]      now_ms      = '0;
  logic                   out_valid;
  logic                   out_stall   = 1'b0;
  logic [CODE_W-1:0]      event_code;
  logic [KEY_FIELD_W-1:0] keyset;
  logic                   cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;

  // local copy of the configuration registers
  logic [CNT_W-1:0] cfg_debounce;
  logic [MS_W-1:0]  cfg_delay;
  logic [MS_W-1:0]  cfg_period;
  logic [MS_W-1:0]  cfg_dclick;

  // local copy of the gesture state
  logic [CNT_W-1:0]       freeze_left [KEYS];
  logic [KEY_FIELD_W-1:0] stable_set;
  logic [KEY_FIELD_W-1:0] prior_set;
  logic [KEY_FIELD_W-1:0] last_press_set;
  logic [TIME_W-1:0]      dclick_deadline;
  logic [TIME_W-1:0]      repeat_deadline;
  logic                   holding;

  gesture_t pending_events [$];

  // stimulus bookkeeping
  logic [TIME_W-1:0]      ms_now;
  logic [KEY_FIELD_W-1:0] prev_gesture_keys = '0;
  int send_idle_pct  = 30;
  int recv_stall_pct = 30;
  int hold_req       = 0;
  int hold_left      = 0;
  int ticks_sent     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  key_debounce_gesture_detector_unit DUT (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .raw_pressed,
    .now_ms,
    .out_valid,
    .out_stall,
    .event_code,
    .keyset,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  // 20 ns clock
  initial begin
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit reached with %0d events outstanding", $time,
               pending_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // result checker: each transaction against the oldest prediction
  always @(posedge clk) begin
    gesture_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected event: expected none, got code %0d keyset %b",
                 $time, event_code, keyset);
        mismatches++;
      end else begin
        want = pending_events.pop_front();
        if (event_code !== want.code) begin
          $display("%0t: event code mismatch: expected %0d, got %0d", $time,
                   want.code, event_code);
          mismatches++;
        end
        if (keyset !== want.keys) begin
          $display("%0t: keyset mismatch: expected %b, got %b", $time,
                   want.keys, keyset);
          mismatches++;
        end
      end
    end
  end

  // state after reset
  task automatic reset_model();
    int k;
    cfg_debounce = DEBOUNCE_TICKS_RST;
    cfg_delay    = REPEAT_DELAY_RST;
    cfg_period   = REPEAT_PERIOD_RST;
    cfg_dclick   = DOUBLE_CLICK_RST;
    for (k = 0; k < KEYS; k++) freeze_left[k] = '0;
    stable_set      = '0;
    prior_set       = '0;
    last_press_set  = '0;
    dclick_deadline = '0;
    repeat_deadline = '0;
    holding         = 1'b0;
    ms_now          = '0;
  endtask

  // debounce one tick, classify the keyset and queue the event it gives
  task automatic classify_tick(input logic [KEY_FIELD_W-1:0] raw,
                               input logic [TIME_W-1:0] t);
    int          k;
    logic        fresh_press;
    event_code_t code;
    fresh_press = 1'b0;
    code        = EV_NONE;
    for (k = 0; k < KEYS; k++) begin
      if (freeze_left[k] != 0) begin
        freeze_left[k] = freeze_left[k] - 1'b1;
      end else if (raw[k] && !stable_set[k]) begin
        stable_set[k]  = 1'b1;
        freeze_left[k] = cfg_debounce;
        fresh_press    = 1'b1;
      end else if (!raw[k] && stable_set[k]) begin
        stable_set[k]  = 1'b0;
        freeze_left[k] = cfg_debounce;
      end
    end
    if (stable_set == '0) begin
      holding         = 1'b0;
      repeat_deadline = '0;
    end else if (stable_set != prior_set) begin
      // keyset changed: restart the repeat timer, report only new presses
      holding = 1'b0;
      if (fresh_press) begin
        code = (stable_set == last_press_set && t < dclick_deadline) ? EV_DOUBLE
                                                                      : EV_PRESS;
        last_press_set  = stable_set;
        dclick_deadline = t + cfg_dclick;
      end
      repeat_deadline = t + cfg_delay;
    end else if (repeat_deadline < t) begin
      code            = holding ? EV_AUTO : EV_HOLD;
      holding         = 1'b1;
      repeat_deadline = t + cfg_period;
    end
    prior_set = stable_set;
    if (code != EV_NONE) pending_events.push_back('{code: code, keys: stable_set});
  endtask

  // offer one tick, possibly after an idle gap, and hold it until accepted
  task automatic send_tick(input logic [KEY_FIELD_W-1:0] raw,
                           input logic [TIME_W-1:0] t);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    raw_pressed <= raw;
    now_ms      <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    classify_tick(raw, t);
    ticks_sent++;
  endtask

  // stop offering and let every predicted event come out
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // one register write; the caller lowers the enable
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // write all four registers back to back; only while idle
  task automatic set_config(input logic [CFG_DATA_W-1:0] debounce_word,
                            input logic [MS_W-1:0] delay,
                            input logic [MS_W-1:0] period,
                            input logic [MS_W-1:0] dclick);
    write_reg(REG_DEBOUNCE_TICKS, debounce_word);
    write_reg(REG_REPEAT_DELAY, delay);
    write_reg(REG_REPEAT_PERIOD, period);
    write_reg(REG_DOUBLE_CLICK, dclick);
    cfg_we       <= 1'b0;
    cfg_debounce = debounce_word[CNT_W-1:0];
    cfg_delay    = delay;
    cfg_period   = period;
    cfg_dclick   = dclick;
  endtask

  // mostly small time steps, sometimes past the deadlines, rarely anywhere
  function automatic logic [TIME_W-1:0] advance_ms();
    int          pick;
    int unsigned span;
    pick = $urandom_range(0, 99);
    span = cfg_delay + cfg_period + cfg_dclick + 2;
    if (pick < 75)      ms_now += $urandom_range(0, 3);
    else if (pick < 92) ms_now += $urandom_range(0, span);
    else if (pick < 98) ms_now += $urandom_range(0, 140000);
    else                ms_now = $urandom;
    return ms_now;
  endfunction

  // random contacts at random times
  task automatic send_noise(input int count);
    repeat (count) send_tick(KEY_FIELD_W'($urandom), advance_ms());
  endtask

  // one press-hold-release gesture with bounce and partial releases
  task automatic play_gesture();
    logic [KEY_FIELD_W-1:0] keys;
    int                     lag;
    lag = cfg_debounce;
    case ($urandom_range(0, 3))
      0: begin
        // same keyset again, a double-click candidate
        keys = (prev_gesture_keys != '0) ? prev_gesture_keys : 6'h01;
      end
      1, 2: begin
        keys = KEY_FIELD_W'(1 << $urandom_range(0, KEYS - 1));
      end
      default: begin
        keys = KEY_FIELD_W'($urandom_range(1, 63));
      end
    endcase
    prev_gesture_keys = keys;
    // contact bounce on the leading edge
    repeat ($urandom_range(0, 3)) send_tick(keys & KEY_FIELD_W'($urandom), advance_ms());
    // steady hold, sometimes past the freeze time
    repeat ($urandom_range(1, 12) + (($urandom_range(0, 3) == 0) ? lag + 2 : 0))
      send_tick(keys, advance_ms());
    // some keys lift while others stay down
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 6)) send_tick(keys & KEY_FIELD_W'($urandom), advance_ms());
    // full release, sometimes long enough to unfreeze
    repeat ($urandom_range(1, 6) + (($urandom_range(0, 2) == 0) ? lag + 1 : 0))
      send_tick('0, advance_ms());
  endtask

  // gestures with the odd burst of noise, starting near the wrap half the time
  task automatic run_gesture_phase(input int count);
    int start;
    start = ticks_sent;
    if ($urandom_range(0, 1) == 1) ms_now = 32'hFFFF_FFFF - $urandom_range(0, 3000);
    while (ticks_sent - start < count) begin
      if ($urandom_range(0, 9) == 0) send_noise($urandom_range(1, 5));
      else play_gesture();
    end
  endtask

  // small random configuration with junk above the debounce byte
  task automatic set_random_config();
    set_config({8'($urandom), 8'($urandom_range(0, 6))},
               MS_W'($urandom_range(0, 40)), MS_W'($urandom_range(0, 10)),
               MS_W'($urandom_range(0, 60)));
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // press, double click, hold, auto repeat, strict hold test, release while
  // held, all keys up, deadline wrap, zero debounce and a frozen key
  task automatic test_directed_gestures();
    set_config(16'd0, REPEAT_DELAY_RST, REPEAT_PERIOD_RST, DOUBLE_CLICK_RST);
    send_tick(6'h00, 32'd0);
    send_tick(6'h01, 32'd100);          // first press
    send_tick(6'h00, 32'd101);          // all keys up
    send_tick(6'h01, 32'd150);          // same key inside the window: double click
    send_tick(6'h01, 32'd650);          // now equals the deadline: nothing yet
    send_tick(6'h01, 32'd651);          // one past: hold
    send_tick(6'h01, 32'd702);          // auto repeat
    send_tick(6'h03, 32'd703);          // second key joins: press
    send_tick(6'h02, 32'd704);          // first key lifts, second stays: no event
    send_tick(6'h02, 32'd2000);         // hold after the restart
    send_tick(6'h00, 32'd2001);
    send_tick(6'h3F, 32'hFFFF_FF00);    // every key, repeat deadline wraps past zero
    send_tick(6'h3F, 32'hFFFF_FFFF);    // wrapped repeat deadline already behind
    send_tick(6'h00, 32'd0);
    send_tick(6'h3F, 32'd1);            // double click across the wrap
    send_tick(6'h20, 32'd2);
    send_tick(6'h21, 32'd3);            // press on a different keyset
    send_tick(6'h00, 32'd4);
    // two ticks of freeze after each change
    wait_quiet();
    set_config(16'd2, REPEAT_DELAY_RST, REPEAT_PERIOD_RST, DOUBLE_CLICK_RST);
    send_tick(6'h01, 32'd10);
    send_tick(6'h00, 32'd11);           // frozen
    send_tick(6'h00, 32'd12);           // frozen
    send_tick(6'h00, 32'd13);           // release lands
    send_tick(6'h01, 32'd14);           // frozen again
    wait_quiet();
  endtask

  // every register at its low end: holds and repeats on each steady tick whose time has moved on
  task automatic test_low_extremes();
    set_config('0, '0, '0, '0);
    run_gesture_phase(250);
    wait_quiet();
  endtask

  // every register at its high end, reached by the large time jumps
  task automatic test_high_extremes();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_gesture_phase(250);
    wait_quiet();
  endtask

  task automatic test_reset_values();
    set_config(CFG_DATA_W'(DEBOUNCE_TICKS_RST), REPEAT_DELAY_RST, REPEAT_PERIOD_RST,
               DOUBLE_CLICK_RST);
    run_gesture_phase(250);
    wait_quiet();
  endtask

  task automatic test_random_configs();
    repeat (4) begin
      set_random_config();
      run_gesture_phase(200);
      wait_quiet();
    end
  endtask

  // a long stretch with neither side idling
  task automatic test_no_idle_stretch();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_random_config();
    run_gesture_phase(200);
    wait_quiet();
    send_idle_pct  = 30;
    recv_stall_pct = 30;
  endtask

  // receiver holds off while every other tick is a press, so the pipe fills
  // and the input stalls; afterwards the sender waits for the backlog
  task automatic test_backpressure();
    int i;
    set_config('0, 16'hFFFF, 16'hFFFF, '0);
    send_idle_pct = 0;
    hold_req      = HOLD_OFF;
    for (i = 0; i < 40; i++) begin
      ms_now++;
      send_tick((i % 2 == 0) ? KEY_FIELD_W'($urandom_range(1, 63)) : '0, ms_now);
    end
    wait_quiet();
    send_idle_pct = 30;
  endtask

  task automatic test_contact_noise();
    set_random_config();
    send_noise(150);
    wait_quiet();
  endtask

  // ------------------------------------------------------------------------
  // sequence
  // ------------------------------------------------------------------------
  initial begin
    reset_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_gestures();
    test_low_extremes();
    test_high_extremes();
    test_reset_values();
    test_random_configs();
    test_no_idle_stretch();
    test_backpressure();
    test_contact_noise();
    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/kdg_pkg.sv
rtl/kdg_debounce.sv
rtl/kdg_classify.sv
rtl/key_debounce_gesture_detector_unit.sv
rtl/kdg_checker.sv
verif/tb_top.sv
